[rtl/core/fbpa_pkg.sv]
// Shared types and constants for the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned POOL_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
  localparam int unsigned NREB_W     = $clog2(POOL_DEPTH + 1);
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PROD_W     = IDX_W + SIZE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(ADDR_W + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    FUNC_ALLOC,
    FUNC_FREE,
    FUNC_REBUILD,
    FUNC_NOP
  } fbpa_func_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_BADADDR
  } fbpa_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE,
    CFG_BLOCK_BYTES,
    CFG_BLOCKS_IN_USE
  } fbpa_cfg_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ALLOC,
    OP_FREE,
    OP_EMPTY,
    OP_BAD,
    OP_REBUILD,
    OP_NOP
  } fbpa_op_e;

  typedef struct packed {
    fbpa_func_e        func;
    logic [ADDR_W-1:0] release_addr;
  } fbpa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_addr;
    fbpa_status_e      status;
    logic [CNT_W-1:0]  used_blocks;
  } fbpa_rsp_t;

  typedef struct packed {
    logic     load;
    logic     rd;
    logic     div_start;
    fbpa_op_e op;
  } fbpa_cmd_t;

  typedef struct packed {
    fbpa_func_e func;
    logic       head_ok;
    logic       below_base;
    logic       div_done;
  } fbpa_stat_t;

endpackage

[rtl/core/fixed_block_pool_allocator_core.sv]
// Top level of the fixed block pool allocator: controller plus datapath.
// A request is taken when start_i is high while busy_o is low; busy_o then stays high
// until the result is out. Each request gives one result on rsp_o, marked by done_o for
// exactly one cycle; the receiver cannot stall it. Alloc (func 0) first reads the link
// memory and forms the block offset product in the decode step, then adds the pool
// base and pops the head in the alloc step; the result is registered. Free (func 1)
// waits for the bit-serial divider that turns the address offset into a block
// index and remainder (one quotient bit per cycle over 32 bits); a free below the pool
// base is rejected in the decode step, without dividing. Rebuild (func 2) and the
// unused func 3 also finish in the decode step: rebuild clears one valid bit per block
// at once, and blocks not touched since then read as the in-order chain. Configuration
// writes on cfg_we_i take effect at once and are only to be made while the block is idle; they do not rebuild the list.
module fixed_block_pool_allocator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  fbpa_pkg::fbpa_req_t            req_i,
  output logic                           done_o,
  output fbpa_pkg::fbpa_rsp_t            rsp_o,
  input  logic                           cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbpa_pkg::CFG_W-1:0]     cfg_wdata_i
);

  import fbpa_pkg::*;

  fbpa_cmd_t  cmd;
  fbpa_stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  fbpa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

endmodule

[rtl/core/fbpa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module fbpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fbpa_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
module fbpa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend_i,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [fbpa_pkg::ADDR_W-1:0] quot_o,
  output logic [fbpa_pkg::SIZE_W-1:0] rem_o
);

  import fbpa_pkg::*;

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0]    quot_q, quot_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W-1:0]    dvs_q, dvs_d;
  logic [SIZE_W:0]      trial;
  logic [SIZE_W:0]      diff;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, quot_q[ADDR_W-1]};
    diff   = trial - {1'b0, dvs_q};
    ge     = (trial >= {1'b0, dvs_q});
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = DIV_CNT_W'(ADDR_W);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (run_q) begin
      quot_d = {quot_q[ADDR_W-2:0], ge};
      rem_d  = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/fbpa_dp.sv]
// Datapath: config registers, free list head, link memory, address math, results.
module fbpa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbpa_pkg::fbpa_cmd_t           cmd_i,
  output fbpa_pkg::fbpa_stat_t          stat_o,
  input  fbpa_pkg::fbpa_req_t           req_i,
  output logic                          done_o,
  output fbpa_pkg::fbpa_rsp_t           rsp_o,
  input  logic                          cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbpa_pkg::CFG_W-1:0]    cfg_wdata_i
);

  import fbpa_pkg::*;

  logic [ADDR_W-1:0]     base_q, base_d;
  logic [SIZE_W-1:0]     bsize_q, bsize_d;
  logic [CNT_W-1:0]      nblk_q, nblk_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic                  head_ok_q, head_ok_d;
  logic [CNT_W-1:0]      used_q, used_d;
  logic [NREB_W-1:0]     nreb_q, nreb_d;
  logic [POOL_DEPTH-1:0] valid_q, valid_d;
  logic                  done_q, done_d;
  fbpa_req_t             req_q;
  logic [PROD_W-1:0]     prod_q;
  fbpa_rsp_t             rsp_q, rsp_d;

  logic [SIZE_W-1:0]     sz;
  logic [NREB_W-1:0]     pool_n;
  logic [ADDR_W-1:0]     quot;
  logic [SIZE_W-1:0]     rem;
  logic                  div_done;
  logic                  free_ok;
  logic                  ram_we;
  logic [IDX_W:0]        ram_rdata;
  logic [NREB_W-1:0]     dflt_nxt;
  logic                  ent_ok;
  logic [IDX_W-1:0]      ent_link;

  assign sz = (bsize_q == '0) ? SIZE_W'(1) : bsize_q;

  always_comb begin
    if (nblk_q == '0) begin
      pool_n = NREB_W'(1);
    end else if (32'(nblk_q) > 32'(POOL_DEPTH)) begin
      pool_n = NREB_W'(POOL_DEPTH);
    end else begin
      pool_n = NREB_W'(nblk_q);
    end
  end

  fbpa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(req_q.release_addr - base_q),
    .divisor_i (sz),
    .done_o    (div_done),
    .quot_o    (quot),
    .rem_o     (rem)
  );

  assign free_ok = (rem == '0) && (quot < 32'(pool_n));
  assign ram_we  = (cmd_i.op == OP_FREE) && free_ok;

  fbpa_ram #(
    .WIDTH(IDX_W + 1),
    .DEPTH(POOL_DEPTH)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(quot[IDX_W-1:0]),
    .wdata_i({head_ok_q, head_q}),
    .re_i   (cmd_i.rd),
    .raddr_i(head_q),
    .rdata_o(ram_rdata)
  );

  // Entries untouched since the last rebuild read as the in-order chain.
  always_comb begin
    dflt_nxt = NREB_W'(head_q) + NREB_W'(1);
    if (valid_q[head_q]) begin
      ent_ok   = ram_rdata[IDX_W];
      ent_link = ram_rdata[IDX_W-1:0];
    end else begin
      ent_ok   = (dflt_nxt < nreb_q);
      ent_link = ent_ok ? dflt_nxt[IDX_W-1:0] : '0;
    end
  end

  always_comb begin
    base_d    = base_q;
    bsize_d   = bsize_q;
    nblk_d    = nblk_q;
    head_d    = head_q;
    head_ok_d = head_ok_q;
    used_d    = used_q;
    nreb_d    = nreb_q;
    valid_d   = valid_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_BASE:     base_d  = cfg_wdata_i[ADDR_W-1:0];
        CFG_BLOCK_BYTES:   bsize_d = cfg_wdata_i[SIZE_W-1:0];
        CFG_BLOCKS_IN_USE: nblk_d  = cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end

    rsp_d.block_addr = '0;
    rsp_d.status     = ST_OK;
    case (cmd_i.op)
      OP_ALLOC: begin
        rsp_d.block_addr = base_q + ADDR_W'(prod_q);
        head_d           = ent_link;
        head_ok_d        = ent_ok;
        if (used_q != COUNT_MAX) begin
          used_d = used_q + CNT_W'(1);
        end
      end
      OP_FREE: begin
        if (free_ok) begin
          valid_d[quot[IDX_W-1:0]] = 1'b1;
          head_d    = quot[IDX_W-1:0];
          head_ok_d = 1'b1;
          if (used_q != '0) begin
            used_d = used_q - CNT_W'(1);
          end
        end else begin
          rsp_d.status = ST_BADADDR;
        end
      end
      OP_EMPTY: rsp_d.status = ST_EMPTY;
      OP_BAD:   rsp_d.status = ST_BADADDR;
      OP_REBUILD: begin
        valid_d   = '0;
        nreb_d    = pool_n;
        head_d    = '0;
        head_ok_d = 1'b1;
        used_d    = '0;
      end
      default: ;
    endcase
    rsp_d.used_blocks = used_d;
    if (cmd_i.op != OP_NONE) begin
      done_d = 1'b1;
    end else begin
      rsp_d = rsp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      bsize_q   <= SIZE_W'(1);
      nblk_q    <= CNT_W'(256);
      head_q    <= '0;
      head_ok_q <= 1'b1;
      used_q    <= '0;
      nreb_q    <= NREB_W'(POOL_DEPTH);
      valid_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      base_q    <= base_d;
      bsize_q   <= bsize_d;
      nblk_q    <= nblk_d;
      head_q    <= head_d;
      head_ok_q <= head_ok_d;
      used_q    <= used_d;
      nreb_q    <= nreb_d;
      valid_q   <= valid_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.rd) begin
      prod_q <= PROD_W'(head_q) * PROD_W'(sz);
    end
    rsp_q <= rsp_d;
  end

  assign stat_o.func       = req_q.func;
  assign stat_o.head_ok    = head_ok_q;
  assign stat_o.below_base = (req_q.release_addr < base_q);
  assign stat_o.div_done   = div_done;

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_done_from_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_i.op != OP_NONE))
    else $error("result strobe without a finishing operation");

  a_rebuild_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_REBUILD) |=> (used_q == '0 && head_ok_q && head_q == '0))
    else $error("rebuild did not reset list head and count");

  a_alloc_has_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_ALLOC) |-> head_ok_q)
    else $error("alloc popped an empty free list");
`endif

endmodule

[rtl/core/fbpa_ctrl.sv]
// Controller: sequences alloc, free, rebuild and no-op requests.
module fbpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output fbpa_pkg::fbpa_cmd_t  cmd_o,
  input  fbpa_pkg::fbpa_stat_t stat_i
);

  import fbpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_DIV
  } state_e;

  state_e    state_q, state_d;
  logic      busy_q;
  fbpa_cmd_t cmd;

  always_comb begin
    state_d       = state_q;
    cmd.load      = 1'b0;
    cmd.rd        = 1'b0;
    cmd.div_start = 1'b0;
    cmd.op        = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (stat_i.func)
          FUNC_ALLOC: begin
            if (stat_i.head_ok) begin
              cmd.rd  = 1'b1;
              state_d = S_ALLOC;
            end else begin
              cmd.op = OP_EMPTY;
            end
          end
          FUNC_FREE: begin
            if (stat_i.below_base) begin
              cmd.op = OP_BAD;
            end else begin
              cmd.div_start = 1'b1;
              state_d       = S_DIV;
            end
          end
          FUNC_REBUILD: cmd.op = OP_REBUILD;
          default:      cmd.op = OP_NOP;
        endcase
      end
      S_ALLOC: begin
        cmd.op  = OP_ALLOC;
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd.op  = OP_FREE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;
  assign cmd_o  = cmd;

`ifndef SYNTHESIS
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> (state_q == S_DIV))
    else $error("divider started without waiting for it");

  a_alloc_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |=> (state_q == S_IDLE && !busy_o))
    else $error("alloc finish did not return to idle");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.rd, cmd.div_start}))
    else $error("conflicting datapath commands");
`endif

endmodule

[tb/fixed_block_pool_allocator_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the fixed block pool allocator core: predictor, driver, monitor.
module fixed_block_pool_allocator_core_test;
  import fbpa_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic                 busy_o;
  fbpa_req_t            req_i       = '0;
  logic                 done_o;
  fbpa_rsp_t            rsp_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  fixed_block_pool_allocator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // allocator state as predicted
  logic [IDX_W-1:0]  pool_link    [POOL_DEPTH];
  logic              pool_link_ok [POOL_DEPTH];
  logic [IDX_W-1:0]  head_idx;
  logic              head_ok;
  logic [CNT_W-1:0]  used_cnt;
  logic [ADDR_W-1:0] cfg_base;
  logic [SIZE_W-1:0] cfg_bytes;
  logic [CNT_W-1:0]  cfg_blocks;

  fbpa_req_t   pending_reqs  [$];
  fbpa_rsp_t   expected_rsps [$];
  fbpa_rsp_t   mon_want;
  int unsigned gap_pct = 0;
  int unsigned gap_plan [4] = '{0, 63, 0, 14};
  int unsigned n_mismatch = 0, n_checked = 0, n_settings = 0;
  int unsigned n_alloc_ok = 0, n_empty = 0, n_free_ok = 0, n_rejected = 0, n_rebuild = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned pool_blocks();
    if (cfg_blocks == '0) return 1;
    if (cfg_blocks > POOL_DEPTH) return POOL_DEPTH;
    return 32'(cfg_blocks);
  endfunction

  function automatic logic [ADDR_W-1:0] block_size();
    return (cfg_bytes == '0) ? ADDR_W'(1) : ADDR_W'(cfg_bytes);
  endfunction

  function automatic void rebuild_chain();
    int unsigned n;
    n = pool_blocks();
    for (int unsigned i = 0; i < POOL_DEPTH; i++) begin
      pool_link[i]    = (i + 1 < n) ? IDX_W'(i + 1) : '0;
      pool_link_ok[i] = (i + 1 < n);
    end
    head_idx = '0;
    head_ok  = 1'b1;
    used_cnt = '0;
  endfunction

  function automatic void predict_response(fbpa_req_t req);
    fbpa_rsp_t         rsp;
    logic [ADDR_W-1:0] ofs;
    logic [ADDR_W-1:0] idx;
    rsp = '0;
    rsp.status = ST_OK;
    case (req.func)
      FUNC_ALLOC: begin
        if (head_ok) begin
          idx = ADDR_W'(head_idx);
          rsp.block_addr = cfg_base + idx * block_size();
          head_ok  = pool_link_ok[idx[IDX_W-1:0]];
          head_idx = pool_link[idx[IDX_W-1:0]];
          if (used_cnt != COUNT_MAX) used_cnt++;
          n_alloc_ok++;
        end else begin
          rsp.status = ST_EMPTY;
          n_empty++;
        end
      end
      FUNC_FREE: begin
        if (req.release_addr < cfg_base) begin
          rsp.status = ST_BADADDR;
          n_rejected++;
        end else begin
          ofs = req.release_addr - cfg_base;
          idx = ofs / block_size();
          if ((ofs % block_size()) != '0 || idx >= pool_blocks()) begin
            rsp.status = ST_BADADDR;
            n_rejected++;
          end else begin
            pool_link[idx[IDX_W-1:0]]    = head_idx;
            pool_link_ok[idx[IDX_W-1:0]] = head_ok;
            head_idx = idx[IDX_W-1:0];
            head_ok  = 1'b1;
            if (used_cnt != '0) used_cnt--;
            n_free_ok++;
          end
        end
      end
      FUNC_REBUILD: begin
        rebuild_chain();
        n_rebuild++;
      end
      default: ;
    endcase
    rsp.used_blocks = used_cnt;
    expected_rsps.push_back(rsp);
  endfunction

  // driver: transfer when start_i && !busy_o
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) predict_response(req_i);
      if (!start_i || !busy_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
          req_i   <= pending_reqs.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected result addr %h status %0d used %0d", $realtime,
                   rsp_o.block_addr, rsp_o.status, rsp_o.used_blocks);
      end else begin
        mon_want = expected_rsps.pop_front();
        n_checked++;
        if (rsp_o.block_addr !== mon_want.block_addr || rsp_o.status !== mon_want.status ||
            rsp_o.used_blocks !== mon_want.used_blocks) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: expected addr %h status %0d used %0d, got addr %h status %0d used %0d",
                     $realtime, mon_want.block_addr, mon_want.status, mon_want.used_blocks,
                     rsp_o.block_addr, rsp_o.status, rsp_o.used_blocks);
        end
      end
    end
  end

  task automatic push_req(fbpa_func_e f, logic [ADDR_W-1:0] a);
    fbpa_req_t r;
    r.func         = f;
    r.release_addr = a;
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(fbpa_cfg_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_POOL_BASE:   cfg_base   = value;
      CFG_BLOCK_BYTES: cfg_bytes  = value[SIZE_W-1:0];
      default:         cfg_blocks = value[CNT_W-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_pool(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] bytes,
                          logic [CNT_W-1:0] blocks);
    write_reg(CFG_POOL_BASE, base);
    write_reg(CFG_BLOCK_BYTES, CFG_W'(bytes));
    write_reg(CFG_BLOCKS_IN_USE, CFG_W'(blocks));
    n_settings++;
  endtask

  // wait until every queued transfer is done and answered
  task automatic drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || start_i || expected_rsps.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic gen_traffic(int unsigned count);
    int unsigned       sel;
    int unsigned       n;
    logic [ADDR_W-1:0] sz;
    logic [ADDR_W-1:0] idx;
    n  = pool_blocks();
    sz = block_size();
    repeat (count) begin
      sel = $urandom_range(99);
      idx = $urandom_range(n - 1);
      if (sel < 44) begin
        push_req(FUNC_ALLOC, $urandom());
      end else if (sel < 76) begin
        push_req(FUNC_FREE, cfg_base + idx * sz);
      end else if (sel < 84 && sz > 1) begin
        push_req(FUNC_FREE, cfg_base + idx * sz + $urandom_range(sz - 1, 1));
      end else if (sel < 84) begin
        push_req(FUNC_FREE, cfg_base + (n + $urandom_range(3)) * sz);
      end else if (sel < 88) begin
        push_req(FUNC_FREE, (cfg_base != '0) ? $urandom_range(cfg_base - 1) : $urandom());
      end else if (sel < 94) begin
        push_req(FUNC_FREE, $urandom());
      end else if (sel < 97) begin
        push_req(FUNC_REBUILD, $urandom());
      end else begin
        push_req(FUNC_NOP, $urandom());
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] bytes;
    logic [CNT_W-1:0]  blocks;
    cfg_base   = '0;
    cfg_bytes  = SIZE_W'(1);
    cfg_blocks = CNT_W'(256);
    rebuild_chain();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: LIFO reuse, past-pool free, unknown request
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '1);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 32'd1);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 32'd256);
    push_req(FUNC_FREE, 32'd255);
    push_req(FUNC_NOP, '1);
    drain();

    // zero size and zero pool count, list kept until rebuild
    set_pool(32'h0000_1000, '0, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 32'h0000_1001);
    push_req(FUNC_FREE, 32'h0000_0FFF);
    push_req(FUNC_FREE, 32'h0000_1000);
    push_req(FUNC_REBUILD, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 32'h0000_1000);
    push_req(FUNC_FREE, 32'h0000_1000);
    drain();

    // largest size, oversized count, block address wrapping past 2^32
    set_pool(32'hFFFF_FF00, '1, '1);
    push_req(FUNC_REBUILD, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 32'h0000_FEFF);
    push_req(FUNC_FREE, 32'hFFFF_FFFF);
    push_req(FUNC_FREE, '0);
    push_req(FUNC_FREE, 32'hFFFF_FF00);
    drain();

    // self-linked block after a double free: count runs into saturation
    set_pool(32'h8000_0000, SIZE_W'(8), CNT_W'(4));
    push_req(FUNC_REBUILD, '0);
    push_req(FUNC_FREE, 32'h8000_0000);
    push_req(FUNC_FREE, 32'h8000_0000);
    repeat (515) push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, 32'h8000_0008);
    drain();

    for (int p = 0; p < 8; p++) begin
      gap_pct = gap_plan[p % 4];
      case ($urandom_range(3))
        0:       base = $urandom_range(255) * 16;
        1:       base = $urandom();
        2:       base = 32'hFFFF_F000 + $urandom_range(4095);
        default: base = 32'h4000_0000;
      endcase
      case ($urandom_range(3))
        0:       bytes = SIZE_W'(1);
        1:       bytes = SIZE_W'($urandom_range(64, 2));
        2:       bytes = '1;
        default: bytes = SIZE_W'($urandom());
      endcase
      if (p == 3) blocks = CNT_W'(256);
      else if (p == 6) blocks = '1;
      else blocks = CNT_W'($urandom_range(16, 1));
      set_pool(base, bytes, blocks);
      if ($urandom_range(3) != 0) push_req(FUNC_REBUILD, $urandom());
      gen_traffic(10);
      drain();
      gen_traffic(10);
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("%0d results over %0d pool settings: %0d allocs, %0d empty, %0d frees, %0d rejects",
             n_checked, n_settings, n_alloc_ok, n_empty, n_free_ok, n_rejected);
    $display("%0d rebuilds, %0d errors", n_rebuild, n_mismatch);
    if (n_mismatch == 0 && expected_rsps.size() == 0) begin
      $display("fixed_block_pool_allocator_core: match");
    end else begin
      $display("fixed_block_pool_allocator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_rsps.size());
    $display("fixed_block_pool_allocator_core: mismatch");
    $finish;
  end

endmodule

[sim.f]
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ram.sv
rtl/core/fbpa_div.sv
rtl/core/fbpa_dp.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fixed_block_pool_allocator_core.sv
tb/fixed_block_pool_allocator_core_test.sv
